@@ rtl/ierr_pkg.sv @@
// ierr_pkg: shared types, constants and checksum helper for the icmp echo reply rewriter
// used by ierr_capture, ierr_reply and icmp_echo_reply_rewriter_unit; no dependencies
`default_nettype none

package ierr_pkg;

  localparam int unsigned WordIdxW = 15;
  localparam int unsigned OffsetW  = 3;

  localparam logic [WordIdxW-1:0] WordIdxMax = '1;

  // ip / icmp field codes
  localparam logic [7:0]  ProtoIcmp       = 8'd1;
  localparam logic [7:0]  IcmpEchoRequest = 8'd8;
  localparam logic [7:0]  IcmpEchoReply   = 8'd0;
  localparam logic [15:0] MinPktLen       = 16'd28;
  localparam logic [7:0]  ReplyTtlReset   = 8'd64;

  // word positions inside the packet
  localparam logic [WordIdxW-1:0] WordIdxIpW0   = 15'd0;
  localparam logic [WordIdxW-1:0] WordIdxIpW1   = 15'd1;
  localparam logic [WordIdxW-1:0] WordIdxIpW2   = 15'd2;
  localparam logic [WordIdxW-1:0] WordIdxIpW3   = 15'd3;
  localparam logic [WordIdxW-1:0] WordIdxIpW4   = 15'd4;
  localparam logic [WordIdxW-1:0] WordIdxIcmpW0 = 15'd5;

  localparam logic [OffsetW-1:0] OffsetDrop  = 3'd0;
  localparam logic [OffsetW-1:0] OffsetFirst = 3'd2;

  localparam logic VerdictDrop  = 1'b0;
  localparam logic VerdictPatch = 1'b1;

  // packet summary handed from the capture stage to the reply stage
  typedef struct packed {
    logic        drop;
    logic [15:0] body_sum;
    logic [15:0] hdr_sum;
    logic [7:0]  msg_code;
    logic [31:0] ip_w3;
    logic [31:0] ip_w4;
  } pkt_summary_t;

  // ones' complement add with end-around carry; a nonzero total stays in 1..0xffff
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

`default_nettype wire

@@ rtl/ierr_capture.sv @@
// ierr_capture: per-word input stage, keeps header fields and running checksums
// depends on ierr_pkg; produces the packet summary on the final word
`default_nettype none

module ierr_capture (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  accept_i,
  input  wire logic [31:0]           packet_word_i,
  input  wire logic                  last_word_i,
  output ierr_pkg::pkt_summary_t     summary_o
);
  import ierr_pkg::*;

  logic [WordIdxW-1:0] word_idx_q, word_idx_d;
  logic [15:0]         body_sum_q, body_sum_d;
  logic [15:0]         hdr_sum_q, hdr_sum_d;
  logic [15:0]         ip_len_q;
  logic [7:0]          ip_proto_q;
  logic [31:0]         ip_w3_q, ip_w4_q;
  logic [7:0]          msg_type_q, msg_code_q;

  logic [16:0] byte_pos;
  logic [16:0] byte_rem;
  logic [31:0] body_mask;
  logic [15:0] body_add;
  logic [15:0] hdr_add;
  logic [WordIdxW:0] word_cnt;
  logic [WordIdxW+2:0] cnt_bytes;

  assign byte_pos = {word_idx_q, 2'b00};
  assign byte_rem = {1'b0, ip_len_q} - byte_pos;

  always_comb begin
    unique case (byte_rem)
      17'd1:   body_mask = 32'hff00_0000;
      17'd2:   body_mask = 32'hffff_0000;
      17'd3:   body_mask = 32'hffff_ff00;
      default: body_mask = 32'hffff_ffff;
    endcase
  end

  assign body_add = oc_add(oc_add(body_sum_q, packet_word_i[31:16] & body_mask[31:16]),
                           packet_word_i[15:0] & body_mask[15:0]);
  assign hdr_add  = oc_add(oc_add(hdr_sum_q, packet_word_i[31:16]), packet_word_i[15:0]);

  always_comb begin
    body_sum_d = body_sum_q;
    hdr_sum_d  = hdr_sum_q;
    if (word_idx_q > WordIdxIcmpW0 && byte_pos < {1'b0, ip_len_q}) begin
      body_sum_d = body_add;
    end
    // word 2 carries ttl, protocol and the old checksum: handled at reply time
    if (word_idx_q == WordIdxIpW0 || word_idx_q == WordIdxIpW1 ||
        word_idx_q == WordIdxIpW3 || word_idx_q == WordIdxIpW4) begin
      hdr_sum_d = hdr_add;
    end
    word_idx_d = (word_idx_q == WordIdxMax) ? word_idx_q : word_idx_q + 1'b1;
  end

  assign word_cnt  = {1'b0, word_idx_q} + 1'b1;
  assign cnt_bytes = {word_cnt, 2'b00};

  // every stored header field is written before it matters: short packets drop first
  always_comb begin
    summary_o.drop      = (word_idx_q <= WordIdxIcmpW0) || (ip_len_q < MinPktLen) ||
                          (cnt_bytes < {2'b00, ip_len_q}) || (ip_proto_q != ProtoIcmp) ||
                          (msg_type_q != IcmpEchoRequest);
    summary_o.body_sum  = body_sum_d;
    summary_o.hdr_sum   = hdr_sum_q;
    summary_o.msg_code  = msg_code_q;
    summary_o.ip_w3     = ip_w3_q;
    summary_o.ip_w4     = ip_w4_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_idx_q <= '0;
      body_sum_q <= '0;
      hdr_sum_q  <= '0;
    end else if (accept_i) begin
      if (last_word_i) begin
        word_idx_q <= '0;
        body_sum_q <= '0;
        hdr_sum_q  <= '0;
      end else begin
        word_idx_q <= word_idx_d;
        body_sum_q <= body_sum_d;
        hdr_sum_q  <= hdr_sum_d;
      end
    end
  end

  // header field captures, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      if (word_idx_q == WordIdxIpW0) ip_len_q <= packet_word_i[15:0];
      if (word_idx_q == WordIdxIpW2) ip_proto_q <= packet_word_i[23:16];
      if (word_idx_q == WordIdxIpW3) ip_w3_q <= packet_word_i;
      if (word_idx_q == WordIdxIpW4) ip_w4_q <= packet_word_i;
      if (word_idx_q == WordIdxIcmpW0) begin
        msg_type_q <= packet_word_i[31:24];
        msg_code_q <= packet_word_i[23:16];
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/ierr_reply.sv @@
// ierr_reply: summary holding register, result sequencer and output register
// depends on ierr_pkg; fed by ierr_capture through the packet summary
`default_nettype none

module ierr_reply (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        load_i,
  input  wire ierr_pkg::pkt_summary_t      summary_i,
  input  wire logic [7:0]                  reply_ttl_i,
  output logic                             slot_free_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic                             verdict_o,
  output logic [ierr_pkg::OffsetW-1:0]     word_offset_o,
  output logic [31:0]                      patch_word_o,
  output logic                             last_result_o
);
  import ierr_pkg::*;

  pkt_summary_t summ_q;
  logic         summ_valid_q;
  logic [1:0]   res_idx_q;

  logic         out_valid_q;
  logic         verdict_q, verdict_d;
  logic [OffsetW-1:0] offset_q, offset_d;
  logic [31:0]  word_q, word_d;
  logic         last_q, last_d;

  logic         emit, emit_last;
  logic [15:0]  hdr_csum, icmp_csum;

  assign emit      = summ_valid_q && (!out_valid_q || out_ready_i);
  assign emit_last = emit && (summ_q.drop || res_idx_q == 2'd3);
  assign slot_free_o = !summ_valid_q || emit_last;

  assign hdr_csum  = ~oc_add(summ_q.hdr_sum, {reply_ttl_i, ProtoIcmp});
  assign icmp_csum = ~oc_add(summ_q.body_sum, {8'd0, summ_q.msg_code});

  always_comb begin
    if (summ_q.drop) begin
      verdict_d = VerdictDrop;
      offset_d  = OffsetDrop;
      word_d    = '0;
      last_d    = 1'b1;
    end else begin
      verdict_d = VerdictPatch;
      offset_d  = OffsetFirst + {1'b0, res_idx_q};
      last_d    = (res_idx_q == 2'd3);
      unique case (res_idx_q)
        2'd0:    word_d = {reply_ttl_i, ProtoIcmp, hdr_csum};
        2'd1:    word_d = summ_q.ip_w4;  // new source is the old destination
        2'd2:    word_d = summ_q.ip_w3;
        default: word_d = {IcmpEchoReply, summ_q.msg_code, icmp_csum};
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      summ_valid_q <= 1'b0;
      res_idx_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (load_i) begin
        summ_valid_q <= 1'b1;
      end else if (emit_last) begin
        summ_valid_q <= 1'b0;
      end
      if (emit_last) begin
        res_idx_q <= '0;
      end else if (emit) begin
        res_idx_q <= res_idx_q + 1'b1;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      summ_q <= summary_i;
    end
    if (emit) begin
      verdict_q <= verdict_d;
      offset_q  <= offset_d;
      word_q    <= word_d;
      last_q    <= last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign verdict_o     = verdict_q;
  assign word_offset_o = offset_q;
  assign patch_word_o  = word_q;
  assign last_result_o = last_q;

endmodule

`default_nettype wire

@@ rtl/icmp_echo_reply_rewriter_unit.sv @@
// icmp_echo_reply_rewriter_unit: top level of the icmp echo reply rewriter
// depends on ierr_pkg, ierr_capture and ierr_reply
//
// usage
// - input channel (in_valid_i / in_ready_o): one big-endian 32-bit packet word per
//   transaction, starting at the ipv4 header (always taken as five words), with
//   last_word_i set on the final word of the packet
// - output channel (out_valid_o / out_ready_i): for an icmp echo request four patch
//   transactions (word offsets 2..5: ttl/protocol/header checksum, swapped addresses,
//   icmp type/code/checksum), otherwise a single drop transaction; last_result_o marks
//   the final transaction of a packet
// - config channel (cfg_valid_i / cfg_ready_o): writes the reply ttl, always ready
// throughput: one packet word per cycle; non-final words are never stalled. a final
//   word waits only while the previous packet still holds the single summary slot,
//   i.e. until its final result has been issued into the output register
// result path: a packet's summary register, then the output register;
//   the four patch words follow in consecutive cycles when the receiver is ready
// reset: word count and checksums clear, reply ttl returns to 64, no results pending
// receiver stall: the output register holds its transaction; new words keep streaming
//   in until a second final word arrives
`default_nettype none

module icmp_echo_reply_rewriter_unit (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // packet word input
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [31:0]               packet_word_i,
  input  wire logic                      last_word_i,
  // result output
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic                           verdict_o,
  output logic [ierr_pkg::OffsetW-1:0]   word_offset_o,
  output logic [31:0]                    patch_word_o,
  output logic                           last_result_o,
  // reply ttl configuration
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [7:0]                cfg_data_i
);
  import ierr_pkg::*;

  logic         reply_ttl_q;
  logic [7:0]   ttl_q;
  logic         in_accept;
  logic         slot_free;
  pkt_summary_t summary;

  // only a final word needs the summary slot
  assign in_ready_o  = !last_word_i || slot_free;
  assign in_accept   = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ttl_q       <= ReplyTtlReset;
      reply_ttl_q <= 1'b0;
    end else begin
      reply_ttl_q <= 1'b1;
      if (cfg_valid_i && cfg_ready_o) begin
        ttl_q <= cfg_data_i;
      end
    end
  end

  ierr_capture u_capture (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (in_accept),
    .packet_word_i (packet_word_i),
    .last_word_i   (last_word_i),
    .summary_o     (summary)
  );

  ierr_reply u_reply (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (in_accept && last_word_i),
    .summary_i     (summary),
    .reply_ttl_i   (ttl_q),
    .slot_free_o   (slot_free),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .verdict_o     (verdict_o),
    .word_offset_o (word_offset_o),
    .patch_word_o  (patch_word_o),
    .last_result_o (last_result_o)
  );

  // a drop is a single all-zero final transaction
  a_drop_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && verdict_o == VerdictDrop |->
      last_result_o && patch_word_o == '0 && word_offset_o == OffsetDrop)
    else $error("drop transaction malformed");

  // patch words only target ip words 2..4 and icmp word 0, ending on the icmp word
  a_patch_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && verdict_o == VerdictPatch |->
      (word_offset_o == 3'd2 || word_offset_o == 3'd3 || word_offset_o == 3'd4 ||
       word_offset_o == 3'd5) && (last_result_o == (word_offset_o == 3'd5)))
    else $error("patch offset out of range");

  // patch words of one packet come in ascending offset order
  a_patch_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && verdict_o == VerdictPatch && !last_result_o |=>
      out_valid_o && verdict_o == VerdictPatch &&
      word_offset_o == $past(word_offset_o) + 3'd1)
    else $error("patch sequence broken");

  // ttl register leaves reset at its default
  a_ttl_reset: assert property (@(posedge clk_i)
    !reply_ttl_q && rst_ni |-> ttl_q == ReplyTtlReset)
    else $error("reply ttl not at reset value");

endmodule

`default_nettype wire
